// ----- rtl/rbdd_pkg.sv -----
// Shared types, constants and helpers for the raw block delta decoder.
// No dependencies; used by every rbdd_* module and the top level.
package rbdd_pkg;

    localparam int unsigned PIXELS_PER_BLOCK = 16;
    localparam int unsigned PIX_IDX_W        = 4;
    localparam int unsigned VAL_W            = 12;
    localparam int unsigned POS_W            = 13;
    localparam int unsigned CFG_W            = 14;
    localparam int unsigned HDR_W            = 11;
    localparam int unsigned DELTA_W          = 7;
    localparam int unsigned SHIFT_W          = 3;
    localparam int unsigned DELTA_BASE       = 30;
    localparam int unsigned STREAM_W         = 128 - DELTA_BASE;
    localparam int unsigned MAX_ROW_PIXELS   = 8192;
    localparam int unsigned PAIR_SPAN        = 32;
    localparam int unsigned COL_STRIDE       = 2;

    localparam logic [CFG_W-1:0] PPR_RESET        = 14'd3936;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = 14'd2640;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PIXELS_PER_ROW = 1'b0;
    localparam t_cfg_idx CFG_FRAME_ROWS     = 1'b1;

    // placement of one block, captured when the block enters the pixel unit
    typedef struct packed {
        logic [POS_W-1:0] col_base;
        logic [POS_W-1:0] row;
        logic             row_done;
    } t_blk_pos;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             last;
        logic             eor;
    } t_pixel;

    // smallest shift (0..3) with 0x80 << shift above (max - min), else 4; 16-bit wrap
    function automatic logic [SHIFT_W-1:0] shift_for(
        input logic [HDR_W-1:0] vmax,
        input logic [HDR_W-1:0] vmin
    );
        logic [15:0] rng;
        rng = {5'b0, vmax} - {5'b0, vmin};
        if (rng < 16'h0080)      shift_for = 3'd0;
        else if (rng < 16'h0100) shift_for = 3'd1;
        else if (rng < 16'h0200) shift_for = 3'd2;
        else if (rng < 16'h0400) shift_for = 3'd3;
        else                     shift_for = 3'd4;
    endfunction

endpackage

// ----- rtl/rbdd_position.sv -----
// Row/column tracker and configuration registers for the block decoder.
// Depends on rbdd_pkg.
module rbdd_position (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  rbdd_pkg::t_cfg_idx           i_cfg_index,
    input  logic [rbdd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_adv,
    output rbdd_pkg::t_blk_pos           o_pos
);

    logic [rbdd_pkg::CFG_W-1:0] r_ppr;
    logic [rbdd_pkg::CFG_W-1:0] r_frame_rows;
    logic [rbdd_pkg::POS_W-1:0] r_pair_base;
    logic                       r_odd;
    logic [rbdd_pkg::POS_W-1:0] r_row;

    logic [rbdd_pkg::CFG_W-1:0] w_next_base;
    logic [rbdd_pkg::CFG_W-1:0] w_next_row;
    logic                       w_row_done;
    logic                       w_row_wrap;

    assign w_next_base = {1'b0, r_pair_base} + rbdd_pkg::CFG_W'(rbdd_pkg::PAIR_SPAN);
    assign w_next_row  = {1'b0, r_row} + rbdd_pkg::CFG_W'(1);
    assign w_row_done  = r_odd &&
                         (w_next_base >= r_ppr ||
                          w_next_base >= rbdd_pkg::CFG_W'(rbdd_pkg::MAX_ROW_PIXELS));
    assign w_row_wrap  = w_next_row >= r_frame_rows ||
                         w_next_row >= rbdd_pkg::CFG_W'(rbdd_pkg::MAX_ROW_PIXELS);

    assign o_pos.col_base = r_pair_base + {{(rbdd_pkg::POS_W-1){1'b0}}, r_odd};
    assign o_pos.row      = r_row;
    assign o_pos.row_done = w_row_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr        <= rbdd_pkg::PPR_RESET;
            r_frame_rows <= rbdd_pkg::FRAME_ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rbdd_pkg::CFG_PIXELS_PER_ROW: r_ppr        <= i_cfg_data;
                rbdd_pkg::CFG_FRAME_ROWS:     r_frame_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_base <= '0;
            r_odd       <= 1'b0;
            r_row       <= '0;
        end else if (i_adv) begin
            if (!r_odd) begin
                r_odd <= 1'b1;
            end else begin
                r_odd <= 1'b0;
                if (w_row_done) begin
                    r_pair_base <= '0;
                    r_row       <= w_row_wrap ? '0 : w_next_row[rbdd_pkg::POS_W-1:0];
                end else begin
                    r_pair_base <= w_next_base[rbdd_pkg::POS_W-1:0];
                end
            end
        end
    end

endmodule

// ----- rtl/rbdd_pixel_unit.sv -----
// Per-block pixel sequencer: holds one block and produces one pixel per step.
// Depends on rbdd_pkg.
module rbdd_pixel_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [63:0]            i_lo,
    input  logic [63:0]            i_hi,
    input  rbdd_pkg::t_blk_pos     i_pos,
    input  logic                   i_step,
    output logic                   o_busy,
    output logic                   o_last,
    output rbdd_pkg::t_pixel       o_pix
);

    localparam logic [rbdd_pkg::PIX_IDX_W-1:0] LastIdx =
        rbdd_pkg::PIX_IDX_W'(rbdd_pkg::PIXELS_PER_BLOCK - 1);

    logic                                r_busy;
    logic [rbdd_pkg::PIX_IDX_W-1:0]      r_idx;
    logic [rbdd_pkg::STREAM_W-1:0]       r_deltas;
    logic [rbdd_pkg::HDR_W-1:0]          r_vmax;
    logic [rbdd_pkg::HDR_W-1:0]          r_vmin;
    logic [rbdd_pkg::PIX_IDX_W-1:0]      r_imax;
    logic [rbdd_pkg::PIX_IDX_W-1:0]      r_imin;
    logic [rbdd_pkg::SHIFT_W-1:0]        r_shift;
    logic [rbdd_pkg::POS_W-1:0]          r_col;
    logic [rbdd_pkg::POS_W-1:0]          r_row;
    logic                                r_row_done;

    logic                                w_is_max;
    logic                                w_is_min;
    logic [rbdd_pkg::VAL_W-1:0]          w_delta_val;

    assign w_is_max    = r_idx == r_imax;
    assign w_is_min    = r_idx == r_imin;
    assign w_delta_val = ({5'b0, r_deltas[rbdd_pkg::DELTA_W-1:0]} << r_shift)
                         + {1'b0, r_vmin};

    assign o_busy = r_busy;
    assign o_last = r_idx == LastIdx;

    always_comb begin
        if (w_is_max)      o_pix.value = {1'b0, r_vmax};
        else if (w_is_min) o_pix.value = {1'b0, r_vmin};
        else               o_pix.value = w_delta_val;
        o_pix.column = r_col;
        o_pix.row    = r_row;
        o_pix.last   = o_last;
        o_pix.eor    = o_last && r_row_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (i_step) begin
            if (o_last) r_busy <= 1'b0;
            r_idx <= r_idx + rbdd_pkg::PIX_IDX_W'(1);
        end
    end

    // payload: header fields, delta stream (zeros shift in past the block end)
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vmax     <= i_lo[10:0];
            r_vmin     <= i_lo[21:11];
            r_imax     <= i_lo[25:22];
            r_imin     <= i_lo[29:26];
            r_shift    <= rbdd_pkg::shift_for(i_lo[10:0], i_lo[21:11]);
            r_deltas   <= {i_hi, i_lo[63:rbdd_pkg::DELTA_BASE]};
            r_col      <= i_pos.col_base;
            r_row      <= i_pos.row;
            r_row_done <= i_pos.row_done;
        end else if (i_step) begin
            r_col <= r_col + rbdd_pkg::POS_W'(rbdd_pkg::COL_STRIDE);
            if (!w_is_max && !w_is_min) begin
                r_deltas <= r_deltas >> rbdd_pkg::DELTA_W;
            end
        end
    end

endmodule

// ----- rtl/raw_block_delta_decoder.sv -----
// Raw block delta decoder: turns 16-byte compressed blocks into pixel transfers.
// Depends on rbdd_pkg, rbdd_position and rbdd_pixel_unit.
//
// Each accepted block (two little-endian 64-bit halves) yields sixteen pixel
// transfers, one per cycle unless i_out_ready stalls, each with its value,
// column, row and block/row-end flags; the single pixel output port bounds
// throughput. A block passes the input register, pixel sequencer and output
// register before its first pixel. The one-block input register lets the next
// block be taken while the current one still drains, and the output register
// decouples the pixel side. Columns advance by two inside a block; blocks
// alternate even and odd phase within each 32-column pair, and the row counter
// advances after the odd block whose next pair would reach pixels_per_row or
// 8192, wrapping at frame_rows or 8192. Configuration (index 0: pixels_per_row,
// index 1: frame_rows) may only be written while no block is in flight.
module raw_block_delta_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // block input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [63:0]                  i_block_low,
    input  logic [63:0]                  i_block_high,
    // pixel output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [11:0]                  o_pixel_value,
    output logic [12:0]                  o_pixel_column,
    output logic [12:0]                  o_pixel_row,
    output logic                         o_last_of_block,
    output logic                         o_end_of_row,
    // configuration write port
    input  logic                         i_cfg_we,
    input  rbdd_pkg::t_cfg_idx           i_cfg_index,
    input  logic [rbdd_pkg::CFG_W-1:0]   i_cfg_data
);

    // input register
    logic                r_in_valid;
    logic [63:0]         r_in_lo;
    logic [63:0]         r_in_hi;

    // output register
    logic                r_out_valid;
    rbdd_pkg::t_pixel    r_out;

    logic                w_load;
    logic                w_step;
    logic                w_pu_busy;
    logic                w_pu_last;
    rbdd_pkg::t_blk_pos  w_pos;
    rbdd_pkg::t_pixel    w_pix;

    // pixel unit steps whenever the output register is free or being drained
    assign w_step = w_pu_busy && (!r_out_valid || i_out_ready);
    // next block moves in when the unit is idle or hands off its last pixel
    assign w_load = r_in_valid && (!w_pu_busy || (w_step && w_pu_last));

    assign o_in_ready = !r_in_valid || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_lo <= i_block_low;
            r_in_hi <= i_block_high;
        end
    end

    rbdd_position u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (w_load),
        .o_pos       (w_pos)
    );

    rbdd_pixel_unit u_pixel_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_lo    (r_in_lo),
        .i_hi    (r_in_hi),
        .i_pos   (w_pos),
        .i_step  (w_step),
        .o_busy  (w_pu_busy),
        .o_last  (w_pu_last),
        .o_pix   (w_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= w_pu_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_pix;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_value   = r_out.value;
    assign o_pixel_column  = r_out.column;
    assign o_pixel_row     = r_out.row;
    assign o_last_of_block = r_out.last;
    assign o_end_of_row    = r_out.eor;

`ifndef NO_ASSERTIONS
    // a buffered block is never dropped or overwritten before it moves in
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_load |=> r_in_valid && $stable(r_in_lo) && $stable(r_in_hi))
        else $error("buffered block lost or changed");

    // pixels of one block follow without gaps once a transfer completes
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_ready && !r_out.last |=> r_out_valid)
        else $error("gap inside a block's pixel burst");

    // row end only on a block's final pixel
    a_eor_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.eor |-> r_out.last)
        else $error("end of row away from block end");
`endif

endmodule
